/* src/bic_pkg.sv */
// ----------------------------------------------------------------------------
// bic_pkg
// Shared types, register map and helpers of the banked interrupt controller.
// ----------------------------------------------------------------------------
package bic_pkg;

    // widths of the fixed transfer fields
    localparam int unsigned BANK_W   = 32;
    localparam int unsigned LOCAL_W  = 8;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned SRC_W    = 7;
    localparam int unsigned BIT_W    = 5;

    // operation codes carried in the low bits of the input tuser
    typedef enum logic [1:0] {
        OP_LEVELS = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // register map
    localparam logic [INDEX_W-1:0] REG_BASIC   = 4'd0;
    localparam logic [INDEX_W-1:0] REG_PEND0   = 4'd1;
    localparam logic [INDEX_W-1:0] REG_PEND1   = 4'd2;
    localparam logic [INDEX_W-1:0] REG_ENSET0  = 4'd3;
    localparam logic [INDEX_W-1:0] REG_ENSET1  = 4'd4;
    localparam logic [INDEX_W-1:0] REG_ENSETL  = 4'd5;
    localparam logic [INDEX_W-1:0] REG_DIS0    = 4'd6;
    localparam logic [INDEX_W-1:0] REG_DIS1    = 4'd7;
    localparam logic [INDEX_W-1:0] REG_DISL    = 4'd8;

    // summary bits of the basic pending register
    localparam logic [BANK_W-1:0] BANK0_SUMMARY = 32'h0000_0100;
    localparam logic [BANK_W-1:0] BANK1_SUMMARY = 32'h0000_0200;

    // base source numbers of the local bank and bank 1
    localparam logic [SRC_W-1:0] LOCAL_BASE = 7'd64;
    localparam logic [SRC_W-1:0] BANK1_BASE = 7'd32;

    // result payload, last field in the lowest bits of the output tdata
    typedef struct packed {
        logic              next_valid;
        logic [SRC_W-1:0]  next_source;
        logic              irq_line;
        logic [BANK_W-1:0] read_data;
    } t_result;

    // index of the lowest set bit, zero when none is set
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [BANK_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = BANK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* src/banked_interrupt_controller_unit.sv */
// ----------------------------------------------------------------------------
// banked_interrupt_controller_unit
// Two 32-source banks and one local bank with enable-set and disable
// registers, pending status, a combined interrupt line and a service hint.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Each input transfer either loads
// the raw levels of all sources, writes an enable-set or disable register,
// reads a register or, for OP_NOP, changes nothing; every result carries the
// read data (zero unless the transfer was a read), the combined interrupt
// line and the next source to service (local bank first, then sources 0-31,
// then 32-63, lowest number first), all taken after the transfer has had
// its effect. The unit takes a new transfer on every cycle while the output
// is not stalled; a transfer passes through the input register, the single
// stage of masking and priority encoding and then the result register. A
// stalled output holds the result register and, once the input register is
// also full, drops s_axis_tready. LOCAL_SOURCES sets how many of the eight
// local level and enable bits are kept; the rest read as zero.
module banked_interrupt_controller_unit #(
    parameter int unsigned LOCAL_SOURCES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: write_data[31:0], bank0_levels[63:32], bank1_levels[95:64],
    //        local_levels[103:96]
    input  logic [103:0] s_axis_tdata,
    // tuser: op[1:0], reg_index[5:2]
    input  logic [5:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: read_data[31:0], irq_line[32], next_source[39:33],
    //        next_valid[40], zero fill[47:41]
    output logic [47:0]  m_axis_tdata
);
    import bic_pkg::*;

    localparam int unsigned LS = LOCAL_SOURCES;

    // input register
    logic                r_in_valid;
    t_op                 r_op;
    logic [INDEX_W-1:0]  r_idx;
    logic [BANK_W-1:0]   r_wdata;
    logic [BANK_W-1:0]   r_lvl0_in;
    logic [BANK_W-1:0]   r_lvl1_in;
    logic [LS-1:0]       r_lvll_in;

    // controller state
    logic [BANK_W-1:0]   r_en0,  n_en0;
    logic [BANK_W-1:0]   r_en1,  n_en1;
    logic [LS-1:0]       r_enl,  n_enl;
    logic [BANK_W-1:0]   r_lvl0, n_lvl0;
    logic [BANK_W-1:0]   r_lvl1, n_lvl1;
    logic [LS-1:0]       r_lvll, n_lvll;

    // result register
    logic                r_out_valid;
    t_result             r_res, n_res;

    logic                w_advance;
    logic [BANK_W-1:0]   w_p0, w_p1;
    logic [LS-1:0]       w_pl;
    logic [BANK_W-1:0]   w_pl_ext;
    logic [BANK_W-1:0]   w_enl_ext;
    logic [BANK_W-1:0]   w_basic;
    logic [BIT_W-1:0]    w_bit_l, w_bit0, w_bit1;

    // the stage moves on when its result register is free or being emptied
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // state update for the item in the input register
    always_comb begin
        n_en0  = r_en0;
        n_en1  = r_en1;
        n_enl  = r_enl;
        n_lvl0 = r_lvl0;
        n_lvl1 = r_lvl1;
        n_lvll = r_lvll;
        if (r_op == OP_LEVELS) begin
            n_lvl0 = r_lvl0_in;
            n_lvl1 = r_lvl1_in;
            n_lvll = r_lvll_in;
        end else if (r_op == OP_WRITE) begin
            unique case (r_idx)
                REG_ENSET0: n_en0 = r_en0 | r_wdata;
                REG_ENSET1: n_en1 = r_en1 | r_wdata;
                REG_ENSETL: n_enl = r_enl | r_wdata[LS-1:0];
                REG_DIS0:   n_en0 = r_en0 & ~r_wdata;
                REG_DIS1:   n_en1 = r_en1 & ~r_wdata;
                REG_DISL:   n_enl = r_enl & ~r_wdata[LS-1:0];
                default:    ; // pending registers and unused indexes ignore writes
            endcase
        end
    end

    // pending status from the updated state
    always_comb begin
        w_p0 = n_lvl0 & n_en0;
        w_p1 = n_lvl1 & n_en1;
        w_pl = n_lvll & n_enl;

        w_pl_ext           = '0;
        w_pl_ext[LS-1:0]   = w_pl;
        w_enl_ext          = '0;
        w_enl_ext[LS-1:0]  = n_enl;

        w_basic = w_pl_ext
                | ((|w_p0) ? BANK0_SUMMARY : '0)
                | ((|w_p1) ? BANK1_SUMMARY : '0);

        w_bit_l = lowest_bit(w_pl_ext);
        w_bit0  = lowest_bit(w_p0);
        w_bit1  = lowest_bit(w_p1);
    end

    // result fields
    always_comb begin
        n_res = '0;
        if (r_op == OP_READ) begin
            unique case (r_idx) inside
                REG_BASIC:            n_res.read_data = w_basic;
                REG_PEND0:            n_res.read_data = w_p0;
                REG_PEND1:            n_res.read_data = w_p1;
                REG_ENSET0, REG_DIS0: n_res.read_data = n_en0;
                REG_ENSET1, REG_DIS1: n_res.read_data = n_en1;
                REG_ENSETL, REG_DISL: n_res.read_data = w_enl_ext;
                default:              n_res.read_data = '0;
            endcase
        end
        n_res.irq_line = (|w_p0) || (|w_p1) || (|w_pl);
        // local bank wins, then bank 0, then bank 1
        if (|w_pl) begin
            n_res.next_source = LOCAL_BASE | SRC_W'(w_bit_l);
            n_res.next_valid  = 1'b1;
        end else if (|w_p0) begin
            n_res.next_source = SRC_W'(w_bit0);
            n_res.next_valid  = 1'b1;
        end else if (|w_p1) begin
            n_res.next_source = BANK1_BASE | SRC_W'(w_bit1);
            n_res.next_valid  = 1'b1;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_en0       <= '0;
            r_en1       <= '0;
            r_enl       <= '0;
            r_lvl0      <= '0;
            r_lvl1      <= '0;
            r_lvll      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_en0       <= n_en0;
                r_en1       <= n_en1;
                r_enl       <= n_enl;
                r_lvl0      <= n_lvl0;
                r_lvl1      <= n_lvl1;
                r_lvll      <= n_lvll;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op      <= t_op'(s_axis_tuser[1:0]);
            r_idx     <= s_axis_tuser[5:2];
            r_wdata   <= s_axis_tdata[31:0];
            r_lvl0_in <= s_axis_tdata[63:32];
            r_lvl1_in <= s_axis_tdata[95:64];
            r_lvll_in <= s_axis_tdata[96 +: LS];
        end
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_res};

`ifndef NO_ASSERTIONS
    // a full input register behind a stalled result must hold off new transfers
    a_backpressure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    // a service hint needs the interrupt line
    a_hint_irq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.next_valid) |-> r_res.irq_line)
        else $error("next source valid without interrupt line");

    // no hint means a zero source number
    a_hint_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.next_valid) |-> (r_res.next_source == '0))
        else $error("next source not zero without a pending source");

    // an accepted item reaches the result register on the following cycle
    // unless the output stage was stalled
    a_progress : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (!r_out_valid || m_axis_tready)) |=> r_out_valid)
        else $error("result lost after stage advance");
`endif

endmodule
